### rtl/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine package
// Field widths, operation and status codes, and the control word that the
// controller hands to every list cell.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_ERASE  = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SHIFT_HOLD  = 2'd0,
    SHIFT_INS   = 2'd1,
    SHIFT_ERS   = 2'd2
  } shift_e;

  // Broadcast to all cells: what to do this cycle and at which list index.
  typedef struct packed {
    shift_e             op;
    logic [POS_W-1:0]   pos;
  } shift_t;

endpackage

### rtl/ple_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface ple_in_if;
  logic                          valid;
  logic                          ready;
  logic [ple_pkg::KIND_W-1:0]    kind;
  logic [ple_pkg::POS_W-1:0]     position;
  logic [ple_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output kind, output position, output value,
                  input ready);
  modport sink   (input valid, input kind, input position, input value,
                  output ready);
endinterface

### rtl/ple_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface ple_out_if;
  logic                          valid;
  logic                          ready;
  logic [ple_pkg::VALUE_W-1:0]   read_value;
  logic [1:0]                    status;
  logic [ple_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, output read_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input read_value, input status,
                  input entry_count, output ready);
endinterface

### rtl/ple_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry; loads the new value, its left neighbor or its right
// neighbor depending on the broadcast shift command.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned SW  = 32
) (
  input  logic             clk_i,
  input  ple_pkg::shift_t  shift_i,
  input  logic [SW-1:0]    value_i,
  input  logic [SW-1:0]    left_i,
  input  logic [SW-1:0]    right_i,
  output logic [SW-1:0]    data_o,
  output logic [SW-1:0]    rd_o
);

  logic [SW-1:0] data_q;
  logic [SW-1:0] data_d;
  logic          at_pos;
  logic          above_pos;

  assign at_pos    = (shift_i.pos == ple_pkg::POS_W'(IDX));
  assign above_pos = (ple_pkg::POS_W'(IDX) > shift_i.pos);

  always_comb begin
    data_d = data_q;
    unique case (shift_i.op)
      ple_pkg::SHIFT_INS: begin
        if (at_pos) begin
          data_d = value_i;
        end else if (above_pos) begin
          data_d = left_i;
        end
      end
      ple_pkg::SHIFT_ERS: begin
        if (at_pos || above_pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = at_pos ? data_q : '0;

endmodule

### rtl/ple_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine controller
// Keeps the entry count, decodes each operation into a shift command for the
// cells and works out the status and count of the result.
// ----------------------------------------------------------------------------
module ple_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [ple_pkg::KIND_W-1:0]    kind_i,
  input  logic [ple_pkg::POS_W-1:0]     pos_i,
  output ple_pkg::shift_t               shift_o,
  output ple_pkg::status_e              status_o,
  output logic                          rd_hit_o,
  output logic [CW-1:0]                 count_o,
  output logic [ple_pkg::COUNT_W-1:0]   count_next_o
);

  logic [CW-1:0]                count_q;
  logic [CW-1:0]                count_d;
  logic [ple_pkg::COUNT_W-1:0]  pos_ext;
  logic [ple_pkg::COUNT_W-1:0]  cnt_ext;
  ple_pkg::shift_e              op;
  logic [ple_pkg::POS_W-1:0]    pos_eff;

  assign pos_ext = ple_pkg::COUNT_W'(pos_i);
  assign cnt_ext = ple_pkg::COUNT_W'(count_q);

  always_comb begin
    count_d  = count_q;
    op       = ple_pkg::SHIFT_HOLD;
    pos_eff  = pos_i;
    status_o = ple_pkg::STATUS_DONE;
    rd_hit_o = 1'b0;
    unique case (ple_pkg::kind_e'(kind_i))
      ple_pkg::KIND_INSERT: begin
        if (count_q == CW'(DEPTH)) begin
          status_o = ple_pkg::STATUS_FULL;
        end else begin
          op      = ple_pkg::SHIFT_INS;
          // Past the end the value is appended.
          pos_eff = (pos_ext > cnt_ext) ? ple_pkg::POS_W'(count_q) : pos_i;
          count_d = count_q + CW'(1);
        end
      end
      ple_pkg::KIND_ERASE: begin
        if (pos_ext >= cnt_ext) begin
          status_o = ple_pkg::STATUS_RANGE;
        end else begin
          op      = ple_pkg::SHIFT_ERS;
          count_d = count_q - CW'(1);
        end
      end
      ple_pkg::KIND_READ: begin
        if (pos_ext >= cnt_ext) begin
          status_o = ple_pkg::STATUS_RANGE;
        end else begin
          rd_hit_o = 1'b1;
        end
      end
      default: status_o = ple_pkg::STATUS_RANGE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign shift_o.op   = accept_i ? op : ple_pkg::SHIFT_HOLD;
  assign shift_o.pos  = pos_eff;
  assign count_o      = count_q;
  assign count_next_o = ple_pkg::COUNT_W'(count_d);

endmodule

### rtl/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of up to DEPTH values with insert, erase and read at a
// position, built as a row of cells that shift together.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_i    | in  | valid / ready | kind, position, value
//  out_o   | out | valid / ready | read_value, status, entry_count
//
// For every word, all cells shift together on the accepting edge, and the
// result is written into the output register on that same edge.
// A new word is accepted whenever the output register is empty or being read,
// so one word per cycle is sustained while the sink keeps up.
// Reset empties the list at once; no clearing pass is needed.
// A stalled result holds the output register and stops further accepts.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ple_in_if.sink     in_i,
  ple_out_if.source  out_o
);

  localparam int unsigned SW = (DATA_WIDTH < ple_pkg::VALUE_W) ? DATA_WIDTH
                                                                : ple_pkg::VALUE_W;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                          accept;
  ple_pkg::shift_t               shift;
  ple_pkg::status_e              status;
  logic                          rd_hit;
  logic [CW-1:0]                 count;
  logic [ple_pkg::COUNT_W-1:0]   count_next;
  logic [SW-1:0]                 value;
  logic [SW-1:0]                 cell_data [DEPTH];
  logic [SW-1:0]                 cell_rd   [DEPTH];
  logic [SW-1:0]                 rd_sel;

  logic                          out_valid_q;
  logic [ple_pkg::VALUE_W-1:0]   read_value_q;
  logic [1:0]                    status_q;
  logic [ple_pkg::COUNT_W-1:0]   entry_count_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign value      = in_i.value[SW-1:0];

  ple_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (in_i.kind),
    .pos_i        (in_i.position),
    .shift_o      (shift),
    .status_o     (status),
    .rd_hit_o     (rd_hit),
    .count_o      (count),
    .count_next_o (count_next)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [SW-1:0] left;
    logic [SW-1:0] right;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_data[k-1];
    end
    // The top cell has no right neighbor and keeps its own word on erase.
    if (k == DEPTH - 1) begin : g_last
      assign right = cell_data[k];
    end else begin : g_inner_r
      assign right = cell_data[k+1];
    end
    ple_cell #(
      .IDX (k),
      .SW  (SW)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .value_i (value),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[k]),
      .rd_o    (cell_rd[k])
    );
  end

  // At most one cell matches the position, so the words can be OR-ed.
  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_sel = rd_sel | cell_rd[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q  <= rd_hit ? ple_pkg::VALUE_W'(rd_sel) : '0;
      status_q      <= status;
      entry_count_q <= count_next;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_value  = read_value_q;
  assign out_o.status      = status_q;
  assign out_o.entry_count = entry_count_q;

  a_count_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ple_pkg::COUNT_W'(count) <= ple_pkg::COUNT_W'(DEPTH)
  ) else $error("entry count exceeds list depth");

  a_full_count : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ple_pkg::STATUS_FULL)
      |-> (entry_count_q == ple_pkg::COUNT_W'(DEPTH))
  ) else $error("full status reported below capacity");

  a_range_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != ple_pkg::STATUS_DONE) |-> (read_value_q == '0)
  ) else $error("refused operation returned a nonzero word");

  a_count_tracks : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> (ple_pkg::COUNT_W'(count) == entry_count_q)
  ) else $error("held count differs from reported count");

endmodule
